>>> rtl/assert_macros.svh
// Assertion macros shared by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("compositor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("compositor assertion failed");

// Next-cycle implication that is also checked across reset.
`define DSC_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("compositor assertion failed");

`endif

>>> rtl/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned NumCh   = 4;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SHADOW_ALPHA    = 3'd0,
        REG_SHADOW_RED      = 3'd1,
        REG_SHADOW_GREEN    = 3'd2,
        REG_SHADOW_BLUE     = 3'd3,
        REG_OPACITY_LEVEL   = 3'd4,
        REG_KEEP_FOREGROUND = 3'd5
    } t_reg_idx;

    // Channel order in every NumCh-wide per-channel array: alpha, red, green, blue.
    localparam int unsigned ChAlpha = 0;

    typedef struct packed {
        logic [7:0]       shadow_alpha;
        logic [2:0][7:0]  shadow_rgb;
        logic [7:0]       opacity;
        logic             keep;
    } t_cfg;

    typedef struct packed {
        logic [7:0]            mask;
        logic                  covered;
        logic [NumCh-1:0][7:0] dst;
    } t_pix;

    typedef struct packed {
        t_pix        pix;
        logic [15:0] ia;
    } t_s1;

    typedef struct packed {
        t_pix                   pix;
        logic [NumCh-1:0][15:0] w;
    } t_s2;

    typedef struct packed {
        t_pix                   pix;
        logic [NumCh-1:0][23:0] t;
    } t_s3;

    typedef struct packed {
        t_pix                   pix;
        logic [NumCh-1:0][7:0]  rep;
        logic [NumCh-1:0][31:0] u;
    } t_s4;

    typedef logic [NumCh-1:0][7:0] t_rgba;

endpackage

`default_nettype wire

>>> rtl/dsc_in_if.sv
`default_nettype none

interface dsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] mask_alpha;
    logic       covered;
    logic [7:0] dest_alpha;
    logic [7:0] dest_red;
    logic [7:0] dest_green;
    logic [7:0] dest_blue;

    modport source (
        output valid, mask_alpha, covered, dest_alpha, dest_red, dest_green, dest_blue,
        input  ready
    );
    modport sink (
        input  valid, mask_alpha, covered, dest_alpha, dest_red, dest_green, dest_blue,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/dsc_out_if.sv
`default_nettype none

interface dsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (
        output valid, out_alpha, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_alpha, out_red, out_green, out_blue,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/dsc_premul.sv
`default_nettype none

module dsc_premul import dsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_cfg i_cfg,
    input  wire logic i_vld,
    input  wire t_pix i_pix,
    output logic      o_vld,
    output t_s2       o_s2
);

    logic r_vld1;
    logic r_vld2;
    t_s1  r_s1;
    t_s2  r_s2;
    t_s1  n_s1;
    t_s2  n_s2;

    always_comb begin
        logic [23:0] prod;
        n_s1.pix = i_pix;
        n_s1.ia  = 16'(i_cfg.shadow_alpha) * 16'(i_cfg.opacity);

        n_s2.pix         = r_s1.pix;
        n_s2.w[ChAlpha]  = r_s1.ia;
        for (int c = 1; c < NumCh; c++) begin
            prod      = 24'(i_cfg.shadow_rgb[c-1]) * 24'(r_s1.ia);
            n_s2.w[c] = prod[23:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_vld = r_vld2;
    assign o_s2  = r_s2;

endmodule

`default_nettype wire

>>> rtl/dsc_weight.sv
`default_nettype none

module dsc_weight import dsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_s2  i_s2,
    output logic      o_vld,
    output t_s4       o_s4
);

    logic r_vld3;
    logic r_vld4;
    t_s3  r_s3;
    t_s4  r_s4;
    t_s3  n_s3;
    t_s4  n_s4;

    always_comb begin
        logic [7:0] k;
        n_s3.pix = i_s2.pix;
        for (int c = 0; c < NumCh; c++) begin
            n_s3.t[c] = 24'(i_s2.w[c]) * 24'(i_s2.pix.mask);
        end

        // Coverage left over by the destination: 255 - dest_alpha.
        k        = ~r_s3.pix.dst[ChAlpha];
        n_s4.pix = r_s3.pix;
        for (int c = 0; c < NumCh; c++) begin
            n_s4.rep[c] = r_s3.t[c][23:16];
            n_s4.u[c]   = 32'(k) * 32'(r_s3.t[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_vld = r_vld4;
    assign o_s4  = r_s4;

endmodule

`default_nettype wire

>>> rtl/dsc_blend.sv
`default_nettype none
`include "assert_macros.svh"

module dsc_blend import dsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_keep,
    input  wire logic i_vld,
    input  wire t_s4  i_s4,
    output logic      o_vld,
    output t_rgba     o_pix
);

    logic  r_vld5;
    t_rgba r_out;
    t_rgba n_out;

    always_comb begin
        logic [8:0] sum;
        for (int c = 0; c < NumCh; c++) begin
            sum = 9'(i_s4.pix.dst[c]) + 9'(i_s4.u[c][31:24]);
            if (i_keep) begin
                if (i_s4.pix.covered) begin
                    n_out[c] = sum[8] ? 8'hFF : sum[7:0];
                end else begin
                    n_out[c] = i_s4.pix.dst[c];
                end
            end else begin
                n_out[c] = i_s4.pix.covered ? i_s4.rep[c] : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld5 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_vld = r_vld5;
    assign o_pix = r_out;

    `DSC_ASSERT_NXT(a_keep_alpha_grows, i_en && i_vld && i_keep,
        r_out[ChAlpha] >= $past(i_s4.pix.dst[ChAlpha]))
    `DSC_ASSERT_NXT(a_replace_alpha_bound, i_en && i_vld && !i_keep,
        r_out[ChAlpha] <= 8'd253)

endmodule

`default_nettype wire

>>> rtl/drop_shadow_pixel_composite.sv
// Drop-shadow compositor for a stream of layer pixels.
// Pixels enter on i_pix (valid/ready): mask alpha, a flag for the offset shadow
// region and the existing premultiplied layer pixel. Results leave on o_pix, one
// per input pixel and in the same order.
// The user must set the shadow color, opacity and mode through the write port (i_cfg_we,
// i_cfg_idx, i_cfg_data) only while no pixel is in flight; the block does not enforce it.
// The datapath is a five-stage pipeline: shadow alpha times opacity, premultiplied
// color, mask weighting, destination weighting, then clamp and select into the
// output register.
// Throughput is one pixel per clock as long as each result on o_pix is taken.
// All stages advance together; when o_pix holds a result that is not taken, the
// whole pipeline holds and i_pix.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: shadow alpha 255,
// black shadow color, opacity 255 and replace mode.
`default_nettype none
`include "assert_macros.svh"

module drop_shadow_pixel_composite import dsc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data,
    dsc_in_if.sink                  i_pix,
    dsc_out_if.source               o_pix
);

    t_cfg  r_cfg;
    logic  en;
    t_pix  in_pix;
    logic  vld2;
    t_s2   s2;
    logic  vld4;
    t_s4   s4;
    logic  vld5;
    t_rgba res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shadow_alpha <= 8'd255;
            r_cfg.shadow_rgb   <= '0;
            r_cfg.opacity      <= 8'd255;
            r_cfg.keep         <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SHADOW_ALPHA:    r_cfg.shadow_alpha  <= i_cfg_data;
                REG_SHADOW_RED:      r_cfg.shadow_rgb[0] <= i_cfg_data;
                REG_SHADOW_GREEN:    r_cfg.shadow_rgb[1] <= i_cfg_data;
                REG_SHADOW_BLUE:     r_cfg.shadow_rgb[2] <= i_cfg_data;
                REG_OPACITY_LEVEL:   r_cfg.opacity       <= i_cfg_data;
                REG_KEEP_FOREGROUND: r_cfg.keep          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign en          = !vld5 || o_pix.ready;
    assign i_pix.ready = en;

    assign in_pix.mask    = i_pix.mask_alpha;
    assign in_pix.covered = i_pix.covered;
    assign in_pix.dst[0]  = i_pix.dest_alpha;
    assign in_pix.dst[1]  = i_pix.dest_red;
    assign in_pix.dst[2]  = i_pix.dest_green;
    assign in_pix.dst[3]  = i_pix.dest_blue;

    dsc_premul u_premul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_vld   (i_pix.valid),
        .i_pix   (in_pix),
        .o_vld   (vld2),
        .o_s2    (s2)
    );

    dsc_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (vld2),
        .i_s2    (s2),
        .o_vld   (vld4),
        .o_s4    (s4)
    );

    dsc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_keep  (r_cfg.keep),
        .i_vld   (vld4),
        .i_s4    (s4),
        .o_vld   (vld5),
        .o_pix   (res)
    );

    assign o_pix.valid     = vld5;
    assign o_pix.out_alpha = res[0];
    assign o_pix.out_red   = res[1];
    assign o_pix.out_green = res[2];
    assign o_pix.out_blue  = res[3];

    `DSC_ASSERT_NXT_ALWAYS(a_reset_empties, !i_rst_n, !o_pix.valid)
    `DSC_ASSERT_IMP(a_stall_only_on_backpressure, !i_pix.ready,
        o_pix.valid && !o_pix.ready)

endmodule

`default_nettype wire
